@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/grmd_pkg.sv @@
package grmd_pkg;

  localparam int NUM_W  = 23;
  localparam int TRIG_W = 14;
  localparam int DX_W   = 23;
  localparam int ACC_W  = 30;
  localparam int PT_W   = 20;
  localparam int CELLS  = 256;

  typedef enum logic [1:0] {
    CFG_FOV  = 2'd0,
    CFG_MAXD = 2'd1,
    CFG_STEP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic wr;
    logic load;
    logic div_step;
    logic trig;
    logic scale;
    logic march;
  } ctrl_t;

  typedef struct packed {
    logic max_zero;
    logic stop;
  } stat_t;

  function automatic logic [12:0] qsine_tab(input logic [6:0] idx);
    logic [12:0] v;
    case (idx)
      7'd0:  v = 13'd0;    7'd1:  v = 13'd101;  7'd2:  v = 13'd201;  7'd3:  v = 13'd301;
      7'd4:  v = 13'd401;  7'd5:  v = 13'd501;  7'd6:  v = 13'd601;  7'd7:  v = 13'd700;
      7'd8:  v = 13'd799;  7'd9:  v = 13'd897;  7'd10: v = 13'd995;  7'd11: v = 13'd1092;
      7'd12: v = 13'd1189; 7'd13: v = 13'd1285; 7'd14: v = 13'd1380; 7'd15: v = 13'd1474;
      7'd16: v = 13'd1567; 7'd17: v = 13'd1660; 7'd18: v = 13'd1751; 7'd19: v = 13'd1842;
      7'd20: v = 13'd1931; 7'd21: v = 13'd2019; 7'd22: v = 13'd2106; 7'd23: v = 13'd2191;
      7'd24: v = 13'd2276; 7'd25: v = 13'd2359; 7'd26: v = 13'd2440; 7'd27: v = 13'd2520;
      7'd28: v = 13'd2598; 7'd29: v = 13'd2675; 7'd30: v = 13'd2751; 7'd31: v = 13'd2824;
      7'd32: v = 13'd2896; 7'd33: v = 13'd2967; 7'd34: v = 13'd3035; 7'd35: v = 13'd3102;
      7'd36: v = 13'd3166; 7'd37: v = 13'd3229; 7'd38: v = 13'd3290; 7'd39: v = 13'd3349;
      7'd40: v = 13'd3406; 7'd41: v = 13'd3461; 7'd42: v = 13'd3513; 7'd43: v = 13'd3564;
      7'd44: v = 13'd3612; 7'd45: v = 13'd3659; 7'd46: v = 13'd3703; 7'd47: v = 13'd3745;
      7'd48: v = 13'd3784; 7'd49: v = 13'd3822; 7'd50: v = 13'd3857; 7'd51: v = 13'd3889;
      7'd52: v = 13'd3920; 7'd53: v = 13'd3948; 7'd54: v = 13'd3973; 7'd55: v = 13'd3996;
      7'd56: v = 13'd4017; 7'd57: v = 13'd4036; 7'd58: v = 13'd4052; 7'd59: v = 13'd4065;
      7'd60: v = 13'd4076; 7'd61: v = 13'd4085; 7'd62: v = 13'd4091; 7'd63: v = 13'd4095;
      7'd64: v = 13'd4096;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

  // Sine magnitude for a quarter-wave position scaled to 10 bits.
  function automatic logic [12:0] qsine_mag(input logic [10:0] p10);
    logic [6:0]  idx;
    logic [3:0]  frac;
    logic [12:0] t0;
    logic [12:0] t1;
    logic [10:0] prod;
    logic [12:0] m;
    idx  = p10[10:4];
    frac = p10[3:0];
    t0   = qsine_tab(idx);
    t1   = qsine_tab(idx + 7'd1);
    prod = {4'b0, 7'(t1 - t0)} * {7'b0, frac};
    if (idx >= 7'd64) begin
      m = 13'd4096;
    end else begin
      m = t0 + {6'b0, prod[10:4]};
    end
    return m;
  endfunction

endpackage

@@ src/grid_ray_march_distance_unit.sv @@
// Channel   Handshake                Beat contents
// config    cfg_we_i                 cfg_idx_i, cfg_data_i
// item in   start && !busy           cmd_i, cell_index_i, cell_is_wall_i, player_x_i,
//                                    player_y_i, player_heading_i, column_i
// result    result_valid_o (1 cycle) column_out_o, distance_steps_o, hit_wall_o
//
// A map write leaves busy low.
// A cast keeps busy high through the reciprocal angle divide, the sine lookup, the step
// scaling, a map read per march step, a check of the last read and the result beat.
// The default depth limit is 160. A zero depth limit skips the march.
// Reset marks every map cell unwritten and returns the state machine to idle and the
// configuration registers to their defaults; results cannot be stalled.
module grid_ray_march_distance_unit import grmd_pkg::*; #(
  parameter int MAP_W      = 16,
  parameter int MAP_H      = 16,
  parameter int SCREEN_W   = 120,
  parameter int ANGLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  cell_index_i,
  input  logic        cell_is_wall_i,
  input  logic [11:0] player_x_i,
  input  logic [11:0] player_y_i,
  input  logic [11:0] player_heading_i,
  input  logic [6:0]  column_i,
  output logic        result_valid_o,
  output logic [6:0]  column_out_o,
  output logic [7:0]  distance_steps_o,
  output logic        hit_wall_o
);

  logic [11:0] fov_q;
  logic [7:0]  maxd_q;
  logic [7:0]  step_q;
  ctrl_t       ctl;
  stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q  <= 12'd512;
      maxd_q <= 8'd160;
      step_q <= 8'd26;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FOV:  fov_q  <= cfg_data_i;
        CFG_MAXD: maxd_q <= cfg_data_i[7:0];
        CFG_STEP: step_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  grmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .stat_i      (stat),
    .ctl_o       (ctl),
    .busy_o      (busy),
    .out_valid_o (result_valid_o)
  );

  grmd_dp #(
    .MAP_W      (MAP_W),
    .MAP_H      (MAP_H),
    .SCREEN_W   (SCREEN_W),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .cell_index_i     (cell_index_i),
    .cell_is_wall_i   (cell_is_wall_i),
    .player_x_i       (player_x_i),
    .player_y_i       (player_y_i),
    .player_heading_i (player_heading_i),
    .column_i         (column_i),
    .fov_i            (fov_q),
    .maxd_i           (maxd_q),
    .step_i           (step_q),
    .column_out_o     (column_out_o),
    .distance_steps_o (distance_steps_o),
    .hit_wall_o       (hit_wall_o)
  );

endmodule

@@ src/grmd_ram.sv @@
module grmd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/grmd_ctrl.sv @@
module grmd_ctrl import grmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  cmd_i,
  input  stat_t stat_i,
  output ctrl_t ctl_o,
  output logic  busy_o,
  output logic  out_valid_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_TRIG  = 6'b000100,
    S_SCALE = 6'b001000,
    S_MARCH = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        ctl_o.wr   = start_i & ~cmd_i;
        ctl_o.load = start_i & cmd_i;
        if (start_i && cmd_i) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        state_d        = S_TRIG;
      end
      S_TRIG: begin
        ctl_o.trig = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        ctl_o.scale = 1'b1;
        state_d     = stat_i.max_zero ? S_OUT : S_MARCH;
      end
      S_MARCH: begin
        ctl_o.march = 1'b1;
        if (stat_i.stop) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

@@ src/grmd_dp.sv @@
module grmd_dp import grmd_pkg::*; #(
  parameter int MAP_W      = 16,
  parameter int MAP_H      = 16,
  parameter int SCREEN_W   = 120,
  parameter int ANGLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctl_i,
  output stat_t       stat_o,
  input  logic [7:0]  cell_index_i,
  input  logic        cell_is_wall_i,
  input  logic [11:0] player_x_i,
  input  logic [11:0] player_y_i,
  input  logic [11:0] player_heading_i,
  input  logic [6:0]  column_i,
  input  logic [11:0] fov_i,
  input  logic [7:0]  maxd_i,
  input  logic [7:0]  step_i,
  output logic [6:0]  column_out_o,
  output logic [7:0]  distance_steps_o,
  output logic        hit_wall_o
);

  localparam int DIV_SH = NUM_W + $clog2(SCREEN_W);
  localparam logic [NUM_W:0] RECIP =
    (NUM_W+1)'(((64'd1 << DIV_SH) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));
  localparam int MAPA_W = $clog2(MAP_W * MAP_H + 1);
  localparam int CX_W   = PT_W - 9;
  localparam int SHL    = (ANGLE_BITS < 12) ? 12 - ANGLE_BITS : 0;
  localparam int SHR    = (ANGLE_BITS > 12) ? ANGLE_BITS - 12 : 0;
  localparam logic [ANGLE_BITS-2:0] QSIZE = {1'b1, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] QOFF  = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  function automatic logic signed [TRIG_W-1:0] sine_of(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]            qd;
    logic [ANGLE_BITS-2:0] p;
    logic [ANGLE_BITS-2:0] pp;
    logic [16:0]           wide;
    logic [12:0]           mag;
    qd   = a[ANGLE_BITS-1 -: 2];
    p    = {1'b0, a[ANGLE_BITS-3:0]};
    pp   = qd[0] ? (QSIZE - p) : p;
    wide = (17'(pp) << SHL) >> SHR;
    mag  = qsine_mag(wide[10:0]);
    return qd[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Operands captured at acceptance.
  logic [11:0] px0_q, py0_q, head_q;
  logic [6:0]  col_q;

  // Column * fov * 16 over the screen width, by a reciprocal multiply.
  logic [NUM_W-1:0] quo_q;
  logic [2*NUM_W:0] quo_prod;
  logic [18:0]      colfov;

  // Direction and march.
  logic [15:0]                 a16;
  logic [ANGLE_BITS-1:0]       ang;
  logic signed [TRIG_W-1:0]    ex_q, ey_q;
  logic signed [DX_W-1:0]      dx_c, dy_c;
  logic signed [ACC_W-1:0]     dx_q, dy_q, accx_q, accy_q;
  logic [8:0]                  n_q;
  logic                        issue;
  logic signed [PT_W-1:0]      px, py;
  logic [CX_W-1:0]             cx, cy;
  logic                        oob;
  logic [MAPA_W-1:0]           addr_full;
  logic [7:0]                  ram_addr;

  // Check stage.
  logic       st_valid_q, st_oob_q, st_inr_q, rd_valid_q;
  logic [8:0] st_n_q;
  logic       ram_rdata;
  logic       wall;
  logic [CELLS-1:0] wv_q;
  logic [7:0] dist_q;
  logic       hit_q;

  assign colfov   = {12'b0, column_i} * {7'b0, fov_i};
  assign quo_prod = {{(NUM_W+1){1'b0}}, quo_q} * {{NUM_W{1'b0}}, RECIP};

  assign a16  = {head_q, 4'b0} - {1'b0, fov_i, 3'b0} + quo_q[15:0];
  assign ang  = a16[15 -: ANGLE_BITS];
  assign dx_c = ex_q * $signed({1'b0, step_i});
  assign dy_c = ey_q * $signed({1'b0, step_i});

  assign px = PT_W'(accx_q >>> 12) + $signed({{(PT_W-12){1'b0}}, px0_q});
  assign py = PT_W'(accy_q >>> 12) + $signed({{(PT_W-12){1'b0}}, py0_q});
  assign cx = px[PT_W-2:8];
  assign cy = py[PT_W-2:8];
  assign oob = px[PT_W-1] | py[PT_W-1] |
               ({1'b0, cx} >= (CX_W+1)'(MAP_W)) | ({1'b0, cy} >= (CX_W+1)'(MAP_H));
  assign addr_full = MAPA_W'(cy) * MAPA_W'(MAP_W) + MAPA_W'(cx);
  assign ram_addr  = 8'(addr_full);
  assign issue     = ctl_i.march & (n_q <= {1'b0, maxd_i});

  assign wall = ~st_oob_q & st_inr_q & rd_valid_q & ram_rdata;

  assign stat_o.max_zero = (maxd_i == 8'd0);
  assign stat_o.stop     = st_valid_q & (st_oob_q | wall | (st_n_q == {1'b0, maxd_i}));

  grmd_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr),
    .waddr_i (cell_index_i),
    .wdata_i (cell_is_wall_i),
    .re_i    (issue),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q       <= '0;
      st_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        wv_q[cell_index_i] <= 1'b1;
      end
      if (ctl_i.scale) begin
        st_valid_q <= 1'b0;
      end else if (ctl_i.march) begin
        st_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      px0_q  <= player_x_i;
      py0_q  <= player_y_i;
      head_q <= player_heading_i;
      col_q  <= column_i;
      quo_q  <= {colfov, 4'b0};
    end else if (ctl_i.div_step) begin
      quo_q <= NUM_W'(quo_prod >> DIV_SH);
    end
    if (ctl_i.trig) begin
      ex_q <= sine_of(ang);
      ey_q <= sine_of(ang + QOFF);
    end
    if (ctl_i.scale) begin
      dx_q   <= {{(ACC_W-DX_W){dx_c[DX_W-1]}}, dx_c};
      dy_q   <= {{(ACC_W-DX_W){dy_c[DX_W-1]}}, dy_c};
      accx_q <= {{(ACC_W-DX_W){dx_c[DX_W-1]}}, dx_c};
      accy_q <= {{(ACC_W-DX_W){dy_c[DX_W-1]}}, dy_c};
      n_q    <= 9'd1;
      dist_q <= 8'd0;
      hit_q  <= 1'b0;
    end else if (issue) begin
      accx_q <= accx_q + dx_q;
      accy_q <= accy_q + dy_q;
      n_q    <= n_q + 9'd1;
    end
    if (issue) begin
      st_n_q     <= n_q;
      st_oob_q   <= oob;
      st_inr_q   <= ((addr_full >> 8) == '0);
      rd_valid_q <= wv_q[ram_addr];
    end
    if (ctl_i.march && stat_o.stop) begin
      hit_q  <= wall;
      dist_q <= wall ? st_n_q[7:0] : maxd_i;
    end
  end

  assign column_out_o     = col_q;
  assign distance_steps_o = dist_q;
  assign hit_wall_o       = hit_q;

endmodule

@@ src/grmd_checker.sv @@
`include "assert_macros.svh"

module grmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        cmd_i,
  input logic        result_valid_o,
  input logic [7:0]  distance_steps_o,
  input logic        hit_wall_o
);

  // A result beat belongs to a cast in flight.
  `ASSERT_ALWAYS(a_result_in_cast, result_valid_o |-> busy, "result beat while idle")

  // Each cast yields one beat, after which the unit returns to idle.
  `ASSERT_CLK(a_single_beat, result_valid_o |=> !result_valid_o && !busy, "extra result beat")

  // A cast makes the unit busy; a map write does not.
  `ASSERT_CLK(a_cast_busy, start && !busy && cmd_i |=> busy && !result_valid_o,
              "cast not taken")
  `ASSERT_CLK(a_write_idle, start && !busy && !cmd_i |=> !busy, "map write held the unit")

  // A wall hit is never reported at step zero.
  `ASSERT_CLK(a_hit_dist, result_valid_o && hit_wall_o |-> distance_steps_o != 8'd0,
              "wall hit with zero distance")

endmodule

bind grid_ray_march_distance_unit grmd_checker u_grmd_checker (.*);
